FILE: hw/rtl/rspe_pkg.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder package
// GF(256) arithmetic helpers, payload types and fixed constants shared by
// the encoder, its generator sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

  // Field polynomial x^8 + x^4 + x^3 + x^2 + 1, low eight bits.
  localparam logic [7:0] FIELD_POLY_LO = 8'h1d;

  // Parity length selected after reset.
  localparam logic [5:0] ECC_RESET = 6'd10;

  typedef logic [7:0] gf_byte_t;

  // Multiply by alpha (x) in GF(256).
  function automatic gf_byte_t gf_xtime(input gf_byte_t a);
    gf_byte_t r;
    r = {a[6:0], 1'b0};
    if (a[7]) begin
      r = r ^ FIELD_POLY_LO;
    end
    return r;
  endfunction

  // Full GF(256) multiply, shift-and-add over the eight bits of b.
  function automatic gf_byte_t gf_mul(input gf_byte_t a, input gf_byte_t b);
    gf_byte_t acc;
    gf_byte_t x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rspe_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the parity length setting.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspe_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] ecc_length;

  modport source (output valid, output ecc_length, input ready);
  modport sink   (input valid, input ecc_length, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rspe_in_if.sv
// ----------------------------------------------------------------------------
// Message byte channel
// Valid/ready channel carrying one message byte and its end-of-block mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspe_in_if;
  logic             valid;
  logic             ready;
  rspe_pkg::gf_byte_t data_byte;
  logic             last_of_block;

  modport source (output valid, output data_byte, output last_of_block, input ready);
  modport sink   (input valid, input data_byte, input last_of_block, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rspe_out_if.sv
// ----------------------------------------------------------------------------
// Parity byte channel
// Valid/ready channel carrying one parity byte and its end-of-block mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface rspe_out_if;
  logic               valid;
  logic               ready;
  rspe_pkg::gf_byte_t parity_byte;
  logic               last_parity;

  modport source (output valid, output parity_byte, output last_parity, input ready);
  modport sink   (input valid, input parity_byte, input last_parity, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rspe_gen.sv
// ----------------------------------------------------------------------------
// Generator polynomial sequencer
// Derives the lower coefficients of prod (x + alpha^k), k = 0 .. n-1, one
// root per cycle after reset or a write of the parity length.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_gen #(
  parameter int MAX_PARITY = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [5:0]          cfg_ecc,
  output rspe_pkg::gf_byte_t       gen_o [MAX_PARITY],
  output logic                     busy_o,
  output logic [((MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1)-1:0] top_idx_o,
  output logic [$clog2(MAX_PARITY + 1)-1:0]                    len_o
);

  localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
  localparam int CNT_W = $clog2(MAX_PARITY + 1);

  rspe_pkg::gf_byte_t gen_r   [MAX_PARITY];
  rspe_pkg::gf_byte_t gen_nxt [MAX_PARITY];
  rspe_pkg::gf_byte_t root_r;
  logic [CNT_W-1:0]   k_r;
  logic [CNT_W-1:0]   len_r;
  logic [IDX_W-1:0]   top_idx_r;
  logic               busy_r;
  logic               load;
  logic [5:0]         ecc_sel;
  logic [CNT_W-1:0]   len_new;

  // Reset loads the default setting through the same path as a write.
  assign load    = !rst_n || cfg_we;
  assign ecc_sel = rst_n ? cfg_ecc : rspe_pkg::ECC_RESET;

  // Clamp the setting to 1 .. MAX_PARITY.
  always_comb begin
    if (ecc_sel == 6'd0) begin
      len_new = CNT_W'(1);
    end else if ({1'b0, ecc_sel} > 7'(MAX_PARITY)) begin
      len_new = CNT_W'(MAX_PARITY);
    end else begin
      len_new = CNT_W'(ecc_sel);
    end
  end

  // One step multiplies the running polynomial by (x + root).
  always_comb begin
    gen_nxt[0] = rspe_pkg::gf_mul(gen_r[0], root_r);
    for (int i = 1; i < MAX_PARITY; i++) begin
      if (CNT_W'(i) <= k_r) begin
        gen_nxt[i] = gen_r[i-1] ^ rspe_pkg::gf_mul(gen_r[i], root_r);
      end else begin
        gen_nxt[i] = gen_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
        gen_r[i] <= (CNT_W'(i) < len_new) ? 8'h01 : 8'h00;
      end
      root_r    <= 8'h02;
      k_r       <= CNT_W'(1);
      len_r     <= len_new;
      top_idx_r <= IDX_W'(len_new - CNT_W'(1));
      busy_r    <= (len_new > CNT_W'(1));
    end else if (busy_r) begin
      gen_r  <= gen_nxt;
      root_r <= rspe_pkg::gf_xtime(root_r);
      if (k_r == len_r - CNT_W'(1)) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r + CNT_W'(1);
      end
    end
  end

  assign gen_o     = gen_r;
  assign busy_o    = busy_r;
  assign top_idx_o = top_idx_r;
  assign len_o     = len_r;

endmodule

`default_nettype wire

FILE: hw/rtl/reed_solomon_parity_encoder.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder
// Systematic GF(256) encoder: message bytes run through a parity LFSR and a
// byte marked last of block releases the parity bytes, highest first.
// ----------------------------------------------------------------------------
// Channel     Dir  Payload                        Transaction
// cfg_chan    in   ecc_length[5:0]                 valid & ready (ready tied high)
// in_chan     in   data_byte[7:0], last_of_block   valid & ready
// out_chan    out  parity_byte[7:0], last_parity   valid & ready
//
// One message byte is taken per cycle while in_chan.ready is high; the LFSR
// update sits between the input register and the parity registers. Parity
// emission overlaps the next block. Input stalls when a second end of block
// arrives before the previous parity is drained, and after reset or a
// setting write while the generator sequencer runs with in_chan.ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder #(
  parameter int MAX_PARITY = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  rspe_cfg_if.sink    cfg_chan,
  rspe_in_if.sink     in_chan,
  rspe_out_if.source  out_chan
);

  localparam int IDX_W = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
  localparam int CNT_W = $clog2(MAX_PARITY + 1);

  rspe_pkg::gf_byte_t gen     [MAX_PARITY];
  rspe_pkg::gf_byte_t par_r   [MAX_PARITY];
  rspe_pkg::gf_byte_t par_upd [MAX_PARITY];
  rspe_pkg::gf_byte_t emit_r  [MAX_PARITY];
  logic               gen_busy;
  logic [IDX_W-1:0]   top_idx;
  logic [CNT_W-1:0]   len;
  logic               cfg_we;
  logic               in_acc;
  logic               out_acc;
  logic               s1_valid_r;
  rspe_pkg::gf_byte_t s1_data_r;
  logic               s1_last_r;
  logic               s1_drain;
  logic               emit_free;
  logic [CNT_W-1:0]   emit_cnt_r;
  rspe_pkg::gf_byte_t fb;

  assign cfg_chan.ready = 1'b1;
  assign cfg_we         = cfg_chan.valid && cfg_chan.ready;

  // Generator coefficients for the current parity length.
  rspe_gen #(
    .MAX_PARITY (MAX_PARITY)
  ) u_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_ecc   (cfg_chan.ecc_length),
    .gen_o     (gen),
    .busy_o    (gen_busy),
    .top_idx_o (top_idx),
    .len_o     (len)
  );

  // The parity buffer is free if empty or handing off its final byte now.
  assign emit_free = (emit_cnt_r == '0) || ((emit_cnt_r == CNT_W'(1)) && out_chan.ready);
  assign s1_drain  = s1_valid_r && (!s1_last_r || emit_free);
  assign in_chan.ready = !gen_busy && (!s1_valid_r || s1_drain);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_drain) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_of_block;
    end
  end

  // LFSR step: each active register takes the one below XOR fb * g[j].
  assign fb = s1_data_r ^ par_r[top_idx];

  always_comb begin
    par_upd[0] = rspe_pkg::gf_mul(fb, gen[0]);
    for (int j = 1; j < MAX_PARITY; j++) begin
      if (IDX_W'(j) <= top_idx) begin
        par_upd[j] = par_r[j-1] ^ rspe_pkg::gf_mul(fb, gen[j]);
      end else begin
        par_upd[j] = par_r[j];
      end
    end
  end

  // Parity registers clear on reset, on a setting write and after a block.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int j = 0; j < MAX_PARITY; j++) begin
        par_r[j] <= 8'h00;
      end
    end else if (s1_drain) begin
      if (s1_last_r) begin
        for (int j = 0; j < MAX_PARITY; j++) begin
          par_r[j] <= 8'h00;
        end
      end else begin
        par_r <= par_upd;
      end
    end
  end

  // Parity output buffer: loaded at end of block, shifted up on each transaction.
  assign out_acc = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_cnt_r <= '0;
    end else if (s1_drain && s1_last_r) begin
      emit_cnt_r <= len;
    end else if (out_acc) begin
      emit_cnt_r <= emit_cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_drain && s1_last_r) begin
      emit_r <= par_upd;
    end else if (out_acc) begin
      for (int j = 1; j < MAX_PARITY; j++) begin
        emit_r[j] <= emit_r[j-1];
      end
    end
  end

  assign out_chan.valid       = (emit_cnt_r != '0);
  assign out_chan.parity_byte = emit_r[top_idx];
  assign out_chan.last_parity = (emit_cnt_r == CNT_W'(1));

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Reed-Solomon parity encoder testbench
// Sends message blocks through the encoder under several parity lengths and
// compares every parity byte with a GF(256) parity LFSR kept in the bench.
// Both channels idle at random, and the receiver holds off for a long
// stretch once so that the encoder fills up and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int         MAX_PARITY   = 32;
  localparam logic [8:0] FIELD_POLY   = 9'h11d;
  localparam int         IDLE_SETTLE  = 8;
  localparam int         END_SETTLE   = 40;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         PRINT_LIMIT  = 20;
  localparam int         PHASE_ITEMS  = 25;
  localparam longint     RUN_LIMIT_NS = 64'd20_000_000;

  typedef struct packed {
    rspe_pkg::gf_byte_t parity;
    logic               last;
  } parity_item_t;

  logic clk;
  logic rst_n;

  rspe_cfg_if cfg_bus ();
  rspe_in_if  in_bus ();
  rspe_out_if out_bus ();

  reed_solomon_parity_encoder #(
    .MAX_PARITY(MAX_PARITY)
  ) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_bus.sink),
    .in_chan (in_bus.sink),
    .out_chan(out_bus.source)
  );

  // Bench copy of the encoder state.
  rspe_pkg::gf_byte_t gen_coeff [MAX_PARITY];
  rspe_pkg::gf_byte_t lfsr_bytes[MAX_PARITY];
  int                 parity_len;
  parity_item_t       expected_parity[$];

  // Run control shared between the test sequence and the channel drivers.
  bit src_gaps;
  bit sink_gaps;
  int hold_off_request;

  int error_count;
  int items_sent;
  int blocks_sent;
  int parity_checked;
  int settings_written;

  // Clock.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // GF(256) product by Horner's rule over the bits of a.
  function automatic rspe_pkg::gf_byte_t gf_product(input rspe_pkg::gf_byte_t a,
                                                    input rspe_pkg::gf_byte_t b);
    logic [8:0] acc;
    acc = 9'd0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[7:0], 1'b0};
      if (acc[8]) begin
        acc = acc ^ FIELD_POLY;
      end
      if (a[i]) begin
        acc = acc ^ {1'b0, b};
      end
    end
    return acc[7:0];
  endfunction

  // Clamp the setting, rebuild the generator and clear the parity registers.
  function void load_parity_length(input logic [5:0] setting);
    rspe_pkg::gf_byte_t root;
    parity_len = (setting == 6'd0) ? 1
               : ((int'(setting) > MAX_PARITY) ? MAX_PARITY : int'(setting));
    for (int i = 0; i < MAX_PARITY; i++) begin
      gen_coeff[i]  = (i < parity_len) ? 8'h01 : 8'h00;
      lfsr_bytes[i] = 8'h00;
    end
    root = 8'h01;
    for (int k = 1; k < parity_len; k++) begin
      root = gf_product(root, 8'h02);
      for (int i = k; i > 0; i--) begin
        gen_coeff[i] = gen_coeff[i - 1] ^ gf_product(gen_coeff[i], root);
      end
      gen_coeff[0] = gf_product(gen_coeff[0], root);
    end
  endfunction

  // Shift one message byte into the LFSR; an end of block releases the parity.
  function void absorb_byte(input rspe_pkg::gf_byte_t value, input logic is_last);
    rspe_pkg::gf_byte_t feedback;
    parity_item_t       item;
    feedback = value ^ lfsr_bytes[parity_len - 1];
    for (int j = parity_len - 1; j > 0; j--) begin
      lfsr_bytes[j] = lfsr_bytes[j - 1] ^ gf_product(feedback, gen_coeff[j]);
    end
    lfsr_bytes[0] = gf_product(feedback, gen_coeff[0]);
    if (is_last) begin
      for (int k = 0; k < parity_len; k++) begin
        item.parity = lfsr_bytes[parity_len - 1 - k];
        item.last   = (k == parity_len - 1);
        expected_parity.push_back(item);
      end
      for (int i = 0; i < MAX_PARITY; i++) begin
        lfsr_bytes[i] = 8'h00;
      end
    end
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 25);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: parity byte %0d, %s: got %02h, expected %02h",
               $realtime, parity_checked, what, got, want);
    end
    error_count++;
  endtask

  // Predict on every accepted transaction and check every parity byte.
  always @(posedge clk) begin : parity_monitor
    parity_item_t want;
    if (!rst_n) begin
      load_parity_length(rspe_pkg::ECC_RESET);
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        load_parity_length(cfg_bus.ecc_length);
      end
      if (in_bus.valid && in_bus.ready) begin
        absorb_byte(in_bus.data_byte, in_bus.last_of_block);
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_parity.size() == 0) begin
          report_mismatch("no parity byte expected", out_bus.parity_byte, 0);
        end else begin
          want = expected_parity.pop_front();
          if (out_bus.parity_byte !== want.parity) begin
            report_mismatch("parity_byte", out_bus.parity_byte, want.parity);
          end
          if (out_bus.last_parity !== want.last) begin
            report_mismatch("last_parity", out_bus.last_parity, want.last);
          end
        end
        parity_checked++;
      end
    end
  end

  // Receiver: random ready pattern, plus a long hold-off on request.
  initial begin : sink_driver
    int run_len;
    int gap;
    int held;
    out_bus.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) begin
      @(posedge clk);
    end
    forever begin
      if (hold_off_request > 0) begin
        held = hold_off_request;
        hold_off_request = 0;
        out_bus.ready <= 1'b0;
        repeat (held) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      run_len = $urandom_range(1, 24);
      repeat (run_len) @(posedge clk);
      gap = sink_gaps ? pick_gap() : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Offer one message byte and wait for its transaction. Valid stays high
  // afterwards so that back-to-back bytes follow without a gap.
  task automatic send_byte(input rspe_pkg::gf_byte_t value, input logic is_last);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.data_byte     <= value;
    in_bus.last_of_block <= is_last;
    do @(posedge clk); while (!in_bus.ready);
    items_sent++;
    if (is_last) begin
      blocks_sent++;
    end
  endtask

  task automatic source_idle();
    in_bus.valid <= 1'b0;
  endtask

  // Send a block of random bytes; the final byte closes it.
  task automatic send_block(input int length);
    for (int i = 0; i < length; i++) begin
      send_byte(rspe_pkg::gf_byte_t'($urandom_range(0, 255)), i == length - 1);
    end
  endtask

  // Wait for all parity to drain, then let the pipeline settle.
  task automatic wait_idle();
    @(posedge clk);
    while (expected_parity.size() != 0) begin
      @(posedge clk);
    end
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic program_parity_length(input logic [5:0] setting);
    source_idle();
    wait_idle();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.ecc_length <= setting;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    settings_written++;
  endtask

  // Generator derived at reset, with all-zero, all-one and mixed bytes.
  task automatic test_reset_setting();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h5a, 1'b1);
  endtask

  // Shortest and longest parity, and settings that clamp to them.
  task automatic test_length_extremes();
    program_parity_length(6'd1);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    program_parity_length(6'd32);
    send_byte(8'hff, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    // A zero setting acts as one parity byte.
    program_parity_length(6'd0);
    send_byte(8'h3c, 1'b1);
    // Settings above the maximum act as the maximum.
    program_parity_length(6'd63);
    send_byte(8'hc3, 1'b0);
    send_byte(8'h7e, 1'b1);
  endtask

  // A setting write in the middle of a block discards the partial parity.
  task automatic test_abandoned_block();
    program_parity_length(6'd7);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    program_parity_length(6'd7);
    send_byte(8'h9a, 1'b0);
    send_byte(8'hbc, 1'b1);
  endtask

  // Hold the output off while short blocks keep arriving at full parity length.
  task automatic test_back_pressure();
    program_parity_length(6'd32);
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    hold_off_request = HOLD_CYCLES;
    for (int i = 0; i < 12; i++) begin
      send_block($urandom_range(1, 2));
    end
  endtask

  // Random blocks under several settings, idling on and off.
  task automatic test_random_traffic();
    int phase_items;
    int length;
    logic [5:0] setting;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: setting = 6'($urandom_range(2, 31));
        1: setting = 6'd32;
        2: setting = 6'd1;
        3: setting = 6'($urandom_range(33, 63));
        default: setting = 6'($urandom_range(0, 63));
      endcase
      program_parity_length(setting);
      // One phase runs with no idling on either side.
      src_gaps  = (phase != 1);
      sink_gaps = (phase != 1);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        length = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                              : $urandom_range(13, 48);
        send_block(length);
        phase_items += length;
      end
      // Sometimes leave a block unfinished for the next setting write.
      if ($urandom_range(0, 1) == 1) begin
        for (int i = 0; i < 3; i++) begin
          send_byte(rspe_pkg::gf_byte_t'($urandom_range(0, 255)), 1'b0);
        end
      end
    end
  endtask

  initial begin : test_sequence
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.data_byte   <= 8'h00;
    in_bus.last_of_block <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.ecc_length <= 6'd0;
    src_gaps         = 1'b1;
    sink_gaps        = 1'b1;
    hold_off_request = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_setting();
    test_length_extremes();
    test_abandoned_block();
    test_back_pressure();
    test_random_traffic();

    source_idle();
    wait_idle();
    repeat (END_SETTLE) @(posedge clk);
    if (expected_parity.size() != 0) begin
      report_mismatch("parity bytes never delivered", 0, expected_parity.size());
    end

    $display("Covered %0d message bytes in %0d blocks, %0d parity bytes checked.",
             items_sent, blocks_sent, parity_checked);
    $display("%0d parity length writes incl. 0, 1, 32, 63 and a mid-block write; %0d errors.",
             settings_written, error_count);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Timeout.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
